>>> design/bond_stretch_energy_gradient_top_macros.svh
// Assertion macros shared by the bond stretch checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef BOND_STRETCH_ENERGY_GRADIENT_TOP_MACROS_SVH
`define BOND_STRETCH_ENERGY_GRADIENT_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define BSEG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bseg: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define BSEG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bseg: next-cycle check failed");

`endif

>>> design/bseg_pkg.sv
// Constants for the bond stretch energy and gradient block.
// No dependencies.
`default_nettype none

package bseg_pkg;
    // divisor of the fallback gradient for coinciding atoms (k * 0.01)
    localparam int unsigned ZERO_DIST_DIV = 100;
    // extra fraction bits of the reciprocal used for k / ZERO_DIST_DIV
    localparam int unsigned RECIP_GUARD   = 7;
endpackage

`default_nettype wire

>>> design/bseg_if.sv
// Request and result channel interfaces of the bond stretch block.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface bseg_in_if #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [INDEX_WIDTH-1:0]        atom_a_index;
    logic [INDEX_WIDTH-1:0]        atom_b_index;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] bz;
    logic [COORD_WIDTH-1:0]        rest_length;
    logic [COORD_WIDTH-1:0]        stiffness;

    modport source (output valid, atom_a_index, atom_b_index, ax, ay, az, bx, by, bz,
                    rest_length, stiffness, input ready);
    modport sink   (input valid, atom_a_index, atom_b_index, ax, ay, az, bx, by, bz,
                    rest_length, stiffness, output ready);
endinterface

interface bseg_out_if #(
    parameter int COORD_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [INDEX_WIDTH-1:0]        out_a_index;
    logic [INDEX_WIDTH-1:0]        out_b_index;
    logic [COORD_WIDTH-1:0]        energy;
    logic signed [COORD_WIDTH-1:0] grad_x;
    logic signed [COORD_WIDTH-1:0] grad_y;
    logic signed [COORD_WIDTH-1:0] grad_z;
    logic                          zero_distance;
    logic                          saturated;

    modport source (output valid, out_a_index, out_b_index, energy, grad_x, grad_y, grad_z,
                    zero_distance, saturated, input ready);
    modport sink   (input valid, out_a_index, out_b_index, energy, grad_x, grad_y, grad_z,
                    zero_distance, saturated, output ready);
endinterface

`default_nettype wire

>>> design/bond_stretch_energy_gradient_top.sv
// Harmonic bond stretch: energy 0.5*k*(d-r0)^2 and gradient k*(d-r0)*(a-b)/d per bond.
// Depends on bseg_pkg and the bseg_in_if / bseg_out_if interfaces.
//
// Usage:
//   i_bond carries one bond per request: two atom indices, both atoms' signed
//   fixed-point coordinates, rest length and stiffness. o_result returns one
//   result per request, in order: echoed indices, energy, three gradient axes,
//   zero_distance and saturated flags.
//   The pipeline has three input stages, one square-root stage per root
//   bit (COORD_WIDTH+1), four multiply and align stages, one divide stage
//   per quotient bit (COORD_WIDTH), and the output register.
//   Throughput is one bond per cycle while the receiver does not stall; the
//   bit-serial square root and the three divide lanes are fully pipelined.
//   When the receiver stalls with a result held, the whole pipeline freezes
//   and i_bond.ready drops in the same cycle; nothing is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits; data registers
//   are not reset.
`default_nettype none

module bond_stretch_energy_gradient_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int INDEX_WIDTH = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bseg_in_if.sink    i_bond,
    bseg_out_if.source o_result
);
    import bseg_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int IW    = INDEX_WIDTH;
    localparam int SQW   = 2 * W + 2;          // sum of squares
    localparam int RW    = W + 1;              // root bits
    localparam int REMW  = RW + 2;             // root remainder
    localparam int DMW   = W + 1;              // |d - r0|
    localparam int DM2W  = 2 * DMW;
    localparam int HW    = DMW;                // split point of wide products
    localparam int EPW   = DM2W + W;           // k * (d-r0)^2
    localparam int KDW   = W + DMW;            // k * |d-r0|
    localparam int NUMW  = KDW + W;            // k * |d-r0| * |a-b|
    localparam int DENW  = RW + F;             // d << F
    localparam int RMW   = DENW + 1;           // divide remainder
    localparam int CMPW  = (NUMW > DENW + W) ? NUMW : DENW + W;
    localparam int KQW   = 2 * W + 1;
    localparam int RSH   = W + RECIP_GUARD;

    localparam logic [RSH:0] RECIP_NUM  = {1'b1, {RSH{1'b0}}};
    localparam logic [RSH:0] RECIP_FULL = RECIP_NUM / ZERO_DIST_DIV;
    localparam logic [W:0]   RECIP      = RECIP_FULL[W:0];
    localparam logic [W-1:0] DIV_W      = W'(ZERO_DIST_DIV);
    localparam logic [W-1:0] POS_LIM    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_LIM    = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [IW-1:0]        idx_a;
        logic [IW-1:0]        idx_b;
        logic [W-1:0]         k;
        logic [W-1:0]         r0;
        logic [2:0][W-1:0]    mag;
        logic [2:0]           neg;
    } t_front;

    typedef struct packed {
        logic [IW-1:0]        idx_a;
        logic [IW-1:0]        idx_b;
        logic [2:0]           sres;
        logic [2:0]           ovf;
        logic                 zero;
        logic [W-1:0]         k100;
        logic [W-1:0]         energy;
        logic                 esat;
    } t_back;

    logic en;
    assign en = !o_result.valid || o_result.ready;
    assign i_bond.ready = en;

    // ---------------- stage A: coordinate differences ----------------
    logic [W-1:0] a_c [3];
    logic [W-1:0] b_c [3];
    t_front       n_a_front;
    logic [W:0]   diff [3];

    always_comb begin
        a_c[0] = i_bond.ax; a_c[1] = i_bond.ay; a_c[2] = i_bond.az;
        b_c[0] = i_bond.bx; b_c[1] = i_bond.by; b_c[2] = i_bond.bz;
        n_a_front.idx_a = i_bond.atom_a_index;
        n_a_front.idx_b = i_bond.atom_b_index;
        n_a_front.k     = i_bond.stiffness;
        n_a_front.r0    = i_bond.rest_length;
        for (int i = 0; i < 3; i++) begin
            diff[i] = {a_c[i][W-1], a_c[i]} - {b_c[i][W-1], b_c[i]};
            n_a_front.neg[i] = diff[i][W];
            n_a_front.mag[i] = diff[i][W] ? W'(-diff[i]) : diff[i][W-1:0];
        end
    end

    logic   r_a_valid;
    t_front r_a_front;

    // ---------------- stage B: squares ----------------
    logic            r_b_valid;
    t_front          r_b_front;
    logic [2*W-1:0]  r_b_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_bond.valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_front <= n_a_front;
            r_b_front <= r_a_front;
            for (int i = 0; i < 3; i++) begin
                r_b_sq[i] <= (2*W)'(r_a_front.mag[i]) * (2*W)'(r_a_front.mag[i]);
            end
        end
    end

    // ---------------- square root, one bit per stage ----------------
    logic            r_s_valid [0:RW];
    t_front          r_s_front [0:RW];
    logic [REMW-1:0] r_s_rem   [0:RW];
    logic [RW-1:0]   r_s_root  [0:RW];
    logic [SQW-1:0]  r_s_bits  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid[0] <= 1'b0;
        end else if (en) begin
            r_s_valid[0] <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_front[0] <= r_b_front;
            r_s_rem[0]   <= '0;
            r_s_root[0]  <= '0;
            r_s_bits[0]  <= SQW'(r_b_sq[0]) + SQW'(r_b_sq[1]) + SQW'(r_b_sq[2]);
        end
    end

    for (genvar j = 1; j <= RW; j++) begin : g_sqrt
        logic [REMW-1:0] rin;
        logic [REMW-1:0] trial;
        logic            ge;

        always_comb begin
            rin   = {r_s_rem[j-1][REMW-3:0], r_s_bits[j-1][SQW-1 -: 2]};
            trial = {r_s_root[j-1], 2'b01};
            ge    = rin >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_valid[j] <= 1'b0;
            end else if (en) begin
                r_s_valid[j] <= r_s_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_s_front[j] <= r_s_front[j-1];
                r_s_rem[j]   <= ge ? rin - trial : rin;
                r_s_root[j]  <= {r_s_root[j-1][RW-2:0], ge};
                r_s_bits[j]  <= r_s_bits[j-1] << 2;
            end
        end
    end

    // ---------------- stage D: |d - r0|, first products ----------------
    logic [RW-1:0]  dist_c;
    logic           dneg_c;
    logic [DMW-1:0] dmag_c;
    logic [KQW-1:0] kq_c;

    always_comb begin
        dist_c = r_s_root[RW];
        dneg_c = dist_c < RW'(r_s_front[RW].r0);
        dmag_c = dneg_c ? DMW'(r_s_front[RW].r0) - DMW'(dist_c)
                        : DMW'(dist_c) - DMW'(r_s_front[RW].r0);
        kq_c   = KQW'(r_s_front[RW].k) * KQW'(RECIP);
    end

    logic            r_d_valid;
    t_front          r_d_front;
    logic [RW-1:0]   r_d_dist;
    logic            r_d_dneg;
    logic [DM2W-1:0] r_d_dm2;
    logic [KDW-1:0]  r_d_kd;
    logic [W-1:0]    r_d_kq0;

    // ---------------- stage E: split wide products ----------------
    logic                  r_e_valid;
    t_front                r_e_front;
    logic                  r_e_dneg;
    logic                  r_e_zero;
    logic [DENW-1:0]       r_e_den;
    logic [W-1:0]          r_e_k100;
    logic [HW+W-1:0]       r_e_elo;
    logic [HW+W-1:0]       r_e_ehi;
    logic [HW+W-1:0]       r_e_nlo [3];
    logic [2*W-1:0]        r_e_nhi [3];
    logic [W-1:0]          rem100_c;

    assign rem100_c = r_d_front.k - W'(r_d_kq0 * DIV_W);

    // ---------------- stage F: recombine ----------------
    logic            r_f_valid;
    t_front          r_f_front;
    logic            r_f_dneg;
    logic            r_f_zero;
    logic [DENW-1:0] r_f_den;
    logic [W-1:0]    r_f_k100;
    logic [EPW-1:0]  r_f_e;
    logic [NUMW-1:0] r_f_num [3];

    // ---------------- stage G: energy, divide setup ----------------
    logic [EPW-1:0] esh_c;
    logic           esat_c;
    t_back          n_g_back;

    always_comb begin
        esh_c  = r_f_e >> (2 * F + 1);
        esat_c = (esh_c >> W) != '0;
        n_g_back.idx_a  = r_f_front.idx_a;
        n_g_back.idx_b  = r_f_front.idx_b;
        n_g_back.zero   = r_f_zero;
        n_g_back.k100   = r_f_k100;
        n_g_back.esat   = esat_c;
        n_g_back.energy = esat_c ? '1 : esh_c[W-1:0];
        for (int i = 0; i < 3; i++) begin
            n_g_back.sres[i] = r_f_dneg ^ r_f_front.neg[i];
            n_g_back.ovf[i]  = CMPW'(r_f_num[i]) >= (CMPW'(r_f_den) << W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_s_valid[RW];
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_front <= r_s_front[RW];
            r_d_dist  <= dist_c;
            r_d_dneg  <= dneg_c;
            r_d_dm2   <= DM2W'(dmag_c) * DM2W'(dmag_c);
            r_d_kd    <= KDW'(r_s_front[RW].k) * KDW'(dmag_c);
            r_d_kq0   <= W'(kq_c >> RSH);

            r_e_front <= r_d_front;
            r_e_dneg  <= r_d_dneg;
            r_e_zero  <= r_d_dist == '0;
            r_e_den   <= {r_d_dist, {F{1'b0}}};
            r_e_k100  <= (rem100_c >= DIV_W) ? r_d_kq0 + W'(1) : r_d_kq0;
            r_e_elo   <= (HW+W)'(r_d_dm2[HW-1:0]) * (HW+W)'(r_d_front.k);
            r_e_ehi   <= (HW+W)'(r_d_dm2[DM2W-1:HW]) * (HW+W)'(r_d_front.k);
            for (int i = 0; i < 3; i++) begin
                r_e_nlo[i] <= (HW+W)'(r_d_kd[HW-1:0]) * (HW+W)'(r_d_front.mag[i]);
                r_e_nhi[i] <= (2*W)'(r_d_kd[KDW-1:HW]) * (2*W)'(r_d_front.mag[i]);
            end

            r_f_front <= r_e_front;
            r_f_dneg  <= r_e_dneg;
            r_f_zero  <= r_e_zero;
            r_f_den   <= r_e_den;
            r_f_k100  <= r_e_k100;
            r_f_e     <= EPW'(r_e_elo) + (EPW'(r_e_ehi) << HW);
            for (int i = 0; i < 3; i++) begin
                r_f_num[i] <= NUMW'(r_e_nlo[i]) + (NUMW'(r_e_nhi[i]) << HW);
            end
        end
    end

    // ---------------- divide lanes, one quotient bit per stage ----------------
    logic            r_q_valid [0:W];
    t_back           r_q_back  [0:W];
    logic [DENW-1:0] r_q_den   [0:W];
    logic [RMW-1:0]  r_q_rem   [0:W][0:2];
    logic [W-1:0]    r_q_quo   [0:W][0:2];
    logic [W-1:0]    r_q_nlow  [0:W][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid[0] <= 1'b0;
        end else if (en) begin
            r_q_valid[0] <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_back[0] <= n_g_back;
            r_q_den[0]  <= r_f_den;
            for (int i = 0; i < 3; i++) begin
                r_q_rem[0][i]  <= RMW'(r_f_num[i] >> W);
                r_q_quo[0][i]  <= '0;
                r_q_nlow[0][i] <= r_f_num[i][W-1:0];
            end
        end
    end

    for (genvar j = 1; j <= W; j++) begin : g_div
        logic [RMW-1:0] rin [3];
        logic [2:0]     ge;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rin[i] = {r_q_rem[j-1][i][RMW-2:0], r_q_nlow[j-1][i][W-1]};
                ge[i]  = rin[i] >= RMW'(r_q_den[j-1]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_valid[j] <= 1'b0;
            end else if (en) begin
                r_q_valid[j] <= r_q_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q_back[j] <= r_q_back[j-1];
                r_q_den[j]  <= r_q_den[j-1];
                for (int i = 0; i < 3; i++) begin
                    r_q_rem[j][i]  <= ge[i] ? rin[i] - RMW'(r_q_den[j-1]) : rin[i];
                    r_q_quo[j][i]  <= {r_q_quo[j-1][i][W-2:0], ge[i]};
                    r_q_nlow[j][i] <= r_q_nlow[j-1][i] << 1;
                end
            end
        end
    end

    // ---------------- output stage: sign and clip ----------------
    t_back        fin_c;
    logic [W-1:0] qmag_c [3];
    logic [W-1:0] lim_c  [3];
    logic [W-1:0] clip_c [3];
    logic [W-1:0] n_grad [3];
    logic [2:0]   neg_c;
    logic [2:0]   gsat_c;

    always_comb begin
        fin_c = r_q_back[W];
        for (int i = 0; i < 3; i++) begin
            neg_c[i]  = !fin_c.zero && fin_c.sres[i];
            qmag_c[i] = fin_c.zero ? fin_c.k100 : r_q_quo[W][i];
            lim_c[i]  = neg_c[i] ? NEG_LIM : POS_LIM;
            gsat_c[i] = (!fin_c.zero && fin_c.ovf[i]) || (qmag_c[i] > lim_c[i]);
            clip_c[i] = gsat_c[i] ? lim_c[i] : qmag_c[i];
            n_grad[i] = neg_c[i] ? W'(-clip_c[i]) : clip_c[i];
        end
    end

    logic          r_o_valid;
    logic [IW-1:0] r_o_a_index;
    logic [IW-1:0] r_o_b_index;
    logic [W-1:0]  r_o_energy;
    logic [W-1:0]  r_o_grad [3];
    logic          r_o_zero;
    logic          r_o_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_q_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_a_index <= fin_c.idx_a;
            r_o_b_index <= fin_c.idx_b;
            r_o_energy  <= fin_c.energy;
            r_o_zero    <= fin_c.zero;
            r_o_sat     <= fin_c.esat || (gsat_c != '0);
            for (int i = 0; i < 3; i++) begin
                r_o_grad[i] <= n_grad[i];
            end
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.out_a_index   = r_o_a_index;
    assign o_result.out_b_index   = r_o_b_index;
    assign o_result.energy        = r_o_energy;
    assign o_result.grad_x        = r_o_grad[0];
    assign o_result.grad_y        = r_o_grad[1];
    assign o_result.grad_z        = r_o_grad[2];
    assign o_result.zero_distance = r_o_zero;
    assign o_result.saturated     = r_o_sat;

endmodule

`default_nettype wire

>>> design/bseg_checker.sv
// Port-level checks for the bond stretch block, bound to its top level.
// Depends on bond_stretch_energy_gradient_top_macros.svh.
`default_nettype none
`include "bond_stretch_energy_gradient_top_macros.svh"

module bseg_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_ready,
    input wire                   i_out_valid,
    input wire                   i_out_ready,
    input wire                   i_zero_distance,
    input wire [COORD_WIDTH-1:0] i_grad_x,
    input wire [COORD_WIDTH-1:0] i_grad_y,
    input wire [COORD_WIDTH-1:0] i_grad_z
);
    // hold a stalled result
    `BSEG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // accept a request exactly when the pipeline can advance
    `BSEG_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, 1'b1, i_in_ready == (!i_out_valid || i_out_ready))
    // coinciding atoms give the same fallback on every axis
    `BSEG_ASSERT_NOW(a_zero_same, i_clk, i_rst_n, i_out_valid && i_zero_distance, i_grad_x == i_grad_y && i_grad_y == i_grad_z)
    // and that fallback is never negative
    `BSEG_ASSERT_NOW(a_zero_pos, i_clk, i_rst_n, i_out_valid && i_zero_distance, !i_grad_x[COORD_WIDTH-1])
endmodule

bind bond_stretch_energy_gradient_top bseg_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_bseg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_bond.ready),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_zero_distance(o_result.zero_distance),
    .i_grad_x       (o_result.grad_x),
    .i_grad_y       (o_result.grad_y),
    .i_grad_z       (o_result.grad_z)
);

`default_nettype wire
